### sv/rdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg: shared constants and helpers for the radix digit converter
// Field widths, character codes, register indexes and the reciprocal
// constants used to divide by the radix.
// ----------------------------------------------------------------------------
package rdc_pkg;

	// Field widths
	localparam int INT_WIDTH       = 32;
	localparam int FRAC_WIDTH      = 16;
	localparam int MAX_FRAC_DIGITS = 16;
	localparam int RADIX_WIDTH     = 3;
	localparam int LIMIT_WIDTH     = 5;
	localparam int CHAR_WIDTH      = 7;
	localparam int CFG_WIDTH       = 5;

	// Most integer digits: a 32-bit magnitude in base 3 needs 21 digits.
	localparam int INT_DIGITS  = 21;
	localparam int DIGIT_WIDTH = 3;
	localparam int CNT_WIDTH   = $clog2(INT_DIGITS + 1);

	// Character codes
	localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'd48;
	localparam logic [CHAR_WIDTH-1:0] CHAR_DOT   = 7'd46;
	localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 7'd45;

	// Radix range
	localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = 3'd3;
	localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = 3'd6;

	// Configuration register indexes
	localparam logic REG_RADIX     = 1'b0;
	localparam logic REG_MAX_FRAC  = 1'b1;

	// Clamp a written radix into the supported range.
	function automatic logic [RADIX_WIDTH-1:0] clamp_radix(input logic [RADIX_WIDTH-1:0] v);
		logic [RADIX_WIDTH-1:0] r;
		r = v;
		if (v < RADIX_MIN)
			r = RADIX_MIN;
		else if (v > RADIX_MAX)
			r = RADIX_MAX;
		return r;
	endfunction

	// Clamp a written fraction digit limit into 1..MAX_FRAC_DIGITS.
	function automatic logic [LIMIT_WIDTH-1:0] clamp_limit(input logic [LIMIT_WIDTH-1:0] v);
		logic [LIMIT_WIDTH-1:0] r;
		r = v;
		if (v == '0)
			r = LIMIT_WIDTH'(1);
		else if (v > LIMIT_WIDTH'(MAX_FRAC_DIGITS))
			r = LIMIT_WIDTH'(MAX_FRAC_DIGITS);
		return r;
	endfunction

	// Reciprocal multiplier for floor(x / radix); the shift is 33 or 34.
	function automatic logic [INT_WIDTH-1:0] recip_mult(input logic [RADIX_WIDTH-1:0] b);
		logic [INT_WIDTH-1:0] m;
		case (b)
			3'd3:    m = 32'hAAAA_AAAB;
			3'd4:    m = 32'h8000_0000;
			3'd5:    m = 32'hCCCC_CCCD;
			3'd6:    m = 32'hAAAA_AAAB;
			default: m = 32'hAAAA_AAAB;
		endcase
		return m;
	endfunction

	// True when the reciprocal product is shifted by 34 rather than 33.
	function automatic logic recip_shift34(input logic [RADIX_WIDTH-1:0] b);
		return (b == 3'd5) || (b == 3'd6);
	endfunction

endpackage

### sv/radix_digit_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter: fixed-point number to ASCII digits in base 3 to 6
// Integer digits are found least significant first with one shared 32x32
// multiplier (reciprocal divide), stacked, and sent most significant first;
// fraction digits reuse the same multiplier for fraction times radix.
// ----------------------------------------------------------------------------
// Integer digits are all found before the first character is sent, with
// one multiplier pass per digit (states DMUL then DREM).
// A new item is accepted only in the idle state, once the last character of
// the previous item is in the output register; the shared multiplier sets the pace.
// Reset: radix 3, fraction digit limit 16, no item in progress, output empty.
module radix_digit_converter (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // [0] is_negative, [32:1] integer_part,
	                               // [48:33] fraction_part, [55:49] zero
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [6:0] character, [7] zero
	output logic        m_tlast,   // last
	// Configuration write port
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [4:0]  cfg_wdata
);

	// Sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DMUL = 4'd1;
	localparam logic [3:0] ST_DREM = 4'd2;
	localparam logic [3:0] ST_SIGN = 4'd3;
	localparam logic [3:0] ST_INT  = 4'd4;
	localparam logic [3:0] ST_DOT  = 4'd5;
	localparam logic [3:0] ST_FMUL = 4'd6;
	localparam logic [3:0] ST_FDIG = 4'd7;

	localparam int IW = rdc_pkg::INT_WIDTH;
	localparam int FW = rdc_pkg::FRAC_WIDTH;
	localparam int RW = rdc_pkg::RADIX_WIDTH;
	localparam int LW = rdc_pkg::LIMIT_WIDTH;
	localparam int CW = rdc_pkg::CHAR_WIDTH;
	localparam int DW = rdc_pkg::DIGIT_WIDTH;
	localparam int NW = rdc_pkg::CNT_WIDTH;

	logic [3:0]    state_q;
	logic [RW-1:0] radix_q;
	logic [LW-1:0] max_frac_q;

	logic          neg_q;
	logic [IW-1:0] ival_q;
	logic [FW-1:0] frac_q;
	logic [RW-1:0] base_q;
	logic [LW-1:0] lim_q;
	logic [IW-1:0] magic_q;
	logic          s34_q;
	logic [NW-1:0] cnt_q;
	logic [LW-1:0] fd_q;
	logic [DW-1:0] digit_mem_q [rdc_pkg::INT_DIGITS];

	logic [IW-1:0]   mul_a;
	logic [IW-1:0]   mul_b;
	logic [2*IW-1:0] prod_q;

	logic [IW-1:0]   quot;
	logic [5:0]      qb;
	logic [DW-1:0]   rem;
	logic [DW-1:0]   fdig;
	logic [FW-1:0]   fnew;
	logic [NW-1:0]   top_idx;
	logic            fdig_last;

	logic            slot_free;
	logic            out_load;
	logic [CW-1:0]   out_char;
	logic            out_last;
	logic            m_tvalid_q;
	logic [CW-1:0]   char_q;
	logic            last_q;

	logic            in_xfer;
	logic            in_neg;
	logic [IW-1:0]   in_int;
	logic [FW-1:0]   in_frac;

	assign in_neg  = s_tdata[0];
	assign in_int  = s_tdata[IW:1];
	assign in_frac = s_tdata[IW+FW:IW+1];

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	// Configuration registers, stored already clamped to their legal range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= rdc_pkg::RADIX_MIN;
			max_frac_q <= LW'(rdc_pkg::MAX_FRAC_DIGITS);
		end else if (cfg_we) begin
			case (cfg_addr)
				rdc_pkg::REG_RADIX:    radix_q    <= rdc_pkg::clamp_radix(cfg_wdata[RW-1:0]);
				rdc_pkg::REG_MAX_FRAC: max_frac_q <= rdc_pkg::clamp_limit(cfg_wdata[LW-1:0]);
				default: ;
			endcase
		end
	end

	// Shared multiplier: reciprocal divide of the integer, or fraction times radix.
	always_comb begin
		if (state_q == ST_DMUL) begin
			mul_a = ival_q;
			mul_b = magic_q;
		end else begin
			mul_a = IW'(frac_q);
			mul_b = IW'(base_q);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= (2*IW)'(mul_a) * (2*IW)'(mul_b);
	end

	// Quotient and remainder of the integer divide; the remainder fits in 3 bits.
	assign quot = s34_q ? IW'(prod_q[2*IW-1:34]) : IW'(prod_q[2*IW-1:33]);
	assign qb   = 6'(quot[2:0]) * 6'(base_q);
	assign rem  = ival_q[DW-1:0] - qb[DW-1:0];

	// Next fraction digit and remaining fraction.
	assign fdig      = prod_q[FW+DW-1:FW];
	assign fnew      = prod_q[FW-1:0];
	assign fdig_last = (fnew == '0) || ((fd_q + LW'(1)) == lim_q);

	assign top_idx   = cnt_q - NW'(1);
	assign slot_free = !m_tvalid_q || m_tready;

	// Character chosen for the output register in the current state.
	always_comb begin
		out_load = 1'b0;
		out_char = rdc_pkg::CHAR_ZERO;
		out_last = 1'b0;
		case (state_q)
			ST_SIGN: begin
				out_load = slot_free && neg_q;
				out_char = rdc_pkg::CHAR_MINUS;
			end
			ST_INT: begin
				out_load = slot_free;
				out_char = rdc_pkg::CHAR_ZERO + CW'(digit_mem_q[top_idx]);
				out_last = (cnt_q == NW'(1)) && (frac_q == '0);
			end
			ST_DOT: begin
				out_load = slot_free;
				out_char = rdc_pkg::CHAR_DOT;
			end
			ST_FDIG: begin
				out_load = slot_free;
				out_char = rdc_pkg::CHAR_ZERO + CW'(fdig);
				out_last = fdig_last;
			end
			default: ;
		endcase
	end

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			fd_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						fd_q <= '0;
						if (in_int == '0) begin
							cnt_q   <= NW'(1);
							state_q <= ST_SIGN;
						end else begin
							cnt_q   <= '0;
							state_q <= ST_DMUL;
						end
					end
				end
				ST_DMUL: state_q <= ST_DREM;
				ST_DREM: begin
					cnt_q   <= cnt_q + NW'(1);
					state_q <= (quot == '0) ? ST_SIGN : ST_DMUL;
				end
				ST_SIGN: begin
					if (!neg_q || slot_free)
						state_q <= ST_INT;
				end
				ST_INT: begin
					if (slot_free) begin
						cnt_q <= top_idx;
						if (cnt_q == NW'(1))
							state_q <= (frac_q != '0) ? ST_DOT : ST_IDLE;
					end
				end
				ST_DOT: begin
					if (slot_free)
						state_q <= ST_FMUL;
				end
				ST_FMUL: state_q <= ST_FDIG;
				ST_FDIG: begin
					if (slot_free) begin
						fd_q    <= fd_q + LW'(1);
						state_q <= fdig_last ? ST_IDLE : ST_FMUL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item operands and the digit stack.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			neg_q   <= in_neg;
			ival_q  <= in_int;
			frac_q  <= in_frac;
			base_q  <= radix_q;
			lim_q   <= max_frac_q;
			magic_q <= rdc_pkg::recip_mult(radix_q);
			s34_q   <= rdc_pkg::recip_shift34(radix_q);
			if (in_int == '0)
				digit_mem_q[0] <= '0;
		end
		if (state_q == ST_DREM) begin
			digit_mem_q[cnt_q] <= rem;
			ival_q             <= quot;
		end
		if (state_q == ST_FDIG && slot_free)
			frac_q <= fnew;
	end

	// Output register: holds one character until its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			char_q <= out_char;
			last_q <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, char_q};
	assign m_tlast  = last_q;

endmodule

### bench/radix_digit_converter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter_test: self-checking bench for the radix digit converter
// Numbers go in on the input stream. For each accepted number, the character
// string that the block should emit is worked out from the current register
// settings and queued. Every character transfer on the output stream is then
// compared with the oldest queued character. Both streams stall at random.
// Registers are rewritten only while the block is idle.
// ----------------------------------------------------------------------------
module radix_digit_converter_test;

	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_REPORTS   = 10;
	localparam int LW            = rdc_pkg::LIMIT_WIDTH;

	// One expected output character.
	typedef struct {
		logic [rdc_pkg::CHAR_WIDTH-1:0] code;
		logic                           is_last;
	} char_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;   // [0] is_negative, [32:1] integer_part,
	                             // [48:33] fraction_part, [55:49] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // [6:0] character, [7] zero
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic        cfg_addr = 1'b0;
	logic [4:0]  cfg_wdata = '0;

	// Register copies as last written, before any clamping.
	logic [rdc_pkg::RADIX_WIDTH-1:0] radix_shadow = 3'd3;
	logic [rdc_pkg::LIMIT_WIDTH-1:0] limit_shadow = 5'd16;

	char_beat_t expected_chars[$];
	int         fault_count = 0;
	int         rx_hold = 0;
	bit         tx_calm = 1'b0;
	bit         rx_calm = 1'b0;

	radix_digit_converter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Work out the character string for one number and queue it.
	function automatic void predict_number(input logic neg, input logic [31:0] mag,
	                                       input logic [15:0] frac);
		logic [rdc_pkg::RADIX_WIDTH-1:0] base;
		logic [rdc_pkg::LIMIT_WIDTH-1:0] limit;
		logic [2:0]                      int_digits[$];
		logic [31:0]                     rest;
		logic [15:0]                     f;
		logic [18:0]                     prod;
		int                              n_frac;
		char_beat_t                      line[$];
		base = radix_shadow;
		if (base < rdc_pkg::RADIX_MIN)
			base = rdc_pkg::RADIX_MIN;
		else if (base > rdc_pkg::RADIX_MAX)
			base = rdc_pkg::RADIX_MAX;
		limit = limit_shadow;
		if (limit == 5'd0)
			limit = 5'd1;
		else if (limit > LW'(rdc_pkg::MAX_FRAC_DIGITS))
			limit = LW'(rdc_pkg::MAX_FRAC_DIGITS);

		// The sign depends on the flag alone, so negative zero keeps its minus.
		if (neg)
			line.push_back('{code: rdc_pkg::CHAR_MINUS, is_last: 1'b0});

		// Integer digits, found least significant first.
		rest = mag;
		if (rest == 32'd0)
			int_digits.push_back(3'd0);
		while (rest != 32'd0) begin
			int_digits.push_front(3'(rest % base));
			rest = rest / base;
		end
		foreach (int_digits[i])
			line.push_back('{code: rdc_pkg::CHAR_ZERO + 7'(int_digits[i]),
			                 is_last: 1'b0});

		// Fraction digits by repeated multiplication until exact or at the limit.
		f = frac;
		if (f != 16'd0) begin
			line.push_back('{code: rdc_pkg::CHAR_DOT, is_last: 1'b0});
			n_frac = 0;
			while (f != 16'd0 && n_frac < int'(limit)) begin
				prod = {3'b0, f} * {16'b0, base};
				line.push_back('{code: rdc_pkg::CHAR_ZERO + 7'(prod[18:16]),
				                 is_last: 1'b0});
				f = prod[15:0];
				n_frac++;
			end
		end

		line[line.size() - 1].is_last = 1'b1;
		foreach (line[i])
			expected_chars.push_back(line[i]);
	endfunction

	// Check each output transfer and draw the stall before the next one.
	always @(posedge clk) begin
		char_beat_t want;
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (expected_chars.size() == 0) begin
				if (fault_count < MAX_REPORTS)
					$display("%0t: character %02h last %b with nothing expected",
						$realtime, m_tdata, m_tlast);
				fault_count++;
			end else begin
				want = expected_chars.pop_front();
				if (m_tdata !== {1'b0, want.code} || m_tlast !== want.is_last) begin
					if (fault_count < MAX_REPORTS)
						$display("%0t: expected character %02h last %b, got %02h last %b",
							$realtime, want.code, want.is_last, m_tdata, m_tlast);
					fault_count++;
				end
			end
			rx_hold = rx_calm ? 0 : $urandom_range(18, 0);
			if (rx_hold != 0)
				m_tready <= 1'b0;
		end else if (rx_hold != 0) begin
			rx_hold--;
		end else if (!m_tready) begin
			m_tready <= 1'b1;
		end
	end

	// Send one number, then leave the chosen gap. With no gap, valid stays
	// high so that the next call can reuse it.
	task automatic send_number(input logic neg, input logic [31:0] mag,
	                           input logic [15:0] frac);
		int gap;
		s_tdata  <= {7'd0, frac, mag, neg};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		predict_number(neg, mag, frac);
		gap = tx_calm ? 0 : $urandom_range(18, 0);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every queued character has come out.
	task automatic wait_for_characters();
		s_tvalid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register once the block is idle.
	task automatic write_reg(input logic idx, input logic [4:0] val);
		wait_for_characters();
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == rdc_pkg::REG_RADIX)
			radix_shadow = val[rdc_pkg::RADIX_WIDTH-1:0];
		else
			limit_shadow = val;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Integer magnitudes: small, short, full width and all ones.
	function automatic logic [31:0] random_magnitude();
		logic [31:0] v;
		case ($urandom_range(4, 0))
			0:       v = $urandom_range(30, 0);
			1:       v = $urandom >> $urandom_range(31, 1);
			2:       v = 32'hFFFF_FFFF;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Fractions: zero, one bit, short dyadic and full width.
	function automatic logic [15:0] random_fraction();
		logic [15:0] v;
		case ($urandom_range(4, 0))
			0:       v = 16'd0;
			1:       v = 16'd1 << $urandom_range(15, 0);
			2:       v = 16'($urandom) & (16'hFFFF << $urandom_range(15, 8));
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	// Settings after reset: base 3, sixteen fraction digits.
	task automatic test_reset_config();
		send_number(1'b0, 32'd0, 16'd0);
		send_number(1'b1, 32'd0, 16'd0);
		send_number(1'b0, 32'hFFFF_FFFF, 16'hFFFF);
		send_number(1'b1, 32'hFFFF_FFFF, 16'h0001);
		send_number(1'b0, 32'd1, 16'h8000);
	endtask

	// Every base, including values below three and the value seven.
	task automatic test_radix_range();
		write_reg(rdc_pkg::REG_RADIX, 5'd6);
		send_number(1'b0, 32'hFFFF_FFFF, 16'hFFFF);
		send_number(1'b1, 32'h1234_5678, 16'h0001);
		write_reg(rdc_pkg::REG_RADIX, 5'd7);
		send_number(1'b0, 32'd35, 16'h5555);
		write_reg(rdc_pkg::REG_RADIX, 5'd0);
		send_number(1'b0, 32'd0, 16'h0001);
		write_reg(rdc_pkg::REG_RADIX, 5'd2);
		send_number(1'b1, 32'd1, 16'h0001);
		write_reg(rdc_pkg::REG_RADIX, 5'd4);
		send_number(1'b0, 32'd255, 16'hC000);
		send_number(1'b0, 32'hFFFF_FFFF, 16'h8000);
		write_reg(rdc_pkg::REG_RADIX, 5'd5);
		send_number(1'b0, 32'hFFFF_FFFF, 16'h0001);
		send_number(1'b1, 32'd5, 16'h3333);
	endtask

	// Fraction digit limits at and beyond both ends.
	task automatic test_fraction_limit();
		write_reg(rdc_pkg::REG_RADIX, 5'd3);
		write_reg(rdc_pkg::REG_MAX_FRAC, 5'd0);
		send_number(1'b1, 32'd0, 16'hFFFF);
		write_reg(rdc_pkg::REG_MAX_FRAC, 5'd1);
		send_number(1'b0, 32'd7, 16'h0001);
		write_reg(rdc_pkg::REG_MAX_FRAC, 5'd31);
		send_number(1'b0, 32'd2, 16'h0001);
		write_reg(rdc_pkg::REG_MAX_FRAC, 5'd17);
		send_number(1'b0, 32'd0, 16'h5555);
	endtask

	// Random numbers over several register settings, with random idling.
	task automatic test_random_numbers();
		logic [4:0] radix_plan[7];
		logic [4:0] limit_plan[7];
		radix_plan = '{5'd3, 5'd6, 5'd4, 5'd5, 5'd7, 5'd1, 5'd3};
		limit_plan = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd12, 5'd16};
		for (int p = 0; p < 7; p++) begin
			if (p == 6) begin
				radix_plan[p] = 5'($urandom_range(7, 0));
				limit_plan[p] = 5'($urandom_range(31, 0));
			end
			write_reg(rdc_pkg::REG_RADIX, radix_plan[p]);
			write_reg(rdc_pkg::REG_MAX_FRAC, limit_plan[p]);
			for (int n = 0; n < 18; n++) begin
				// Hold off the sender once until the output side has caught up.
				if (p == 1 && n == 9)
					wait_for_characters();
				send_number(1'($urandom), random_magnitude(), random_fraction());
			end
		end
	endtask

	// Full-rate stretch with neither side idling.
	task automatic test_back_to_back();
		write_reg(rdc_pkg::REG_RADIX, 5'd5);
		write_reg(rdc_pkg::REG_MAX_FRAC, 5'd16);
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		for (int n = 0; n < 24; n++)
			send_number(1'($urandom), random_magnitude(), random_fraction());
		wait_for_characters();
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// Test sequence.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_radix_range();
		test_fraction_limit();
		test_random_numbers();
		test_back_to_back();
		wait_for_characters();
		if (fault_count == 0)
			$display("** radix_digit_converter: PASSED **");
		else
			$display("** radix_digit_converter: FAILED **");
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#4_000_000;
		$display("** radix_digit_converter: FAILED **");
		$finish;
	end

endmodule
